@@ hw/rtl/uitp_pkg.sv @@
// Package for the unsigned integer text parser: word types, constants and defaults.
`default_nettype none
package uitp_pkg;

  localparam int unsigned MAX_LEN_DEF     = 4095;
  localparam int unsigned VALUE_WIDTH_DEF = 64;

  localparam int unsigned BASE_W   = 6;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned END_W    = 12;
  localparam int unsigned OUT_VAL_W = 64;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_TWO   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

  // Digit code for a byte that is neither a decimal digit nor a letter.
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7A;
  localparam logic [7:0] CH_UPX   = 8'h58;
  localparam logic [7:0] CH_LOX   = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } in_word_t;

  typedef struct packed {
    logic [OUT_VAL_W-1:0] parsed_value;
    logic [END_W-1:0]     end_offset;
    logic                 digits_found;
    logic                 value_overflowed;
  } out_word_t;

  // A character after classification by the front end.
  typedef struct packed {
    logic               start;
    logic               is_space;
    logic               is_zero;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
  } class_t;

  typedef struct packed {
    logic   valid;
    class_t data;
  } q_head_t;

endpackage
`default_nettype wire

@@ hw/rtl/uitp_front.sv @@
// Front end: accepts input words and classifies each character.
`default_nettype none
module uitp_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire uitp_pkg::in_word_t in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output uitp_pkg::class_t       q_push_data
);

  logic [7:0] c;

  assign c        = in_data.char_code;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_push_data.start    = in_data.string_start;
    q_push_data.is_space = (c == uitp_pkg::CH_SPACE) ||
                           (c >= uitp_pkg::CH_TAB && c <= uitp_pkg::CH_CR);
    q_push_data.is_zero  = (c == uitp_pkg::CH_ZERO);
    q_push_data.is_x     = (c == uitp_pkg::CH_LOX) || (c == uitp_pkg::CH_UPX);
    if (c >= uitp_pkg::CH_ZERO && c <= uitp_pkg::CH_NINE) begin
      q_push_data.digit = uitp_pkg::DIGIT_W'(c - uitp_pkg::CH_ZERO);
    end else if (c >= uitp_pkg::CH_LOA && c <= uitp_pkg::CH_LOZ) begin
      q_push_data.digit = uitp_pkg::DIGIT_W'(c - uitp_pkg::CH_LOA + 8'd10);
    end else if (c >= uitp_pkg::CH_UPA && c <= uitp_pkg::CH_UPZ) begin
      q_push_data.digit = uitp_pkg::DIGIT_W'(c - uitp_pkg::CH_UPA + 8'd10);
    end else begin
      q_push_data.digit = uitp_pkg::DIGIT_NONE;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/uitp_queue.sv @@
// Short queue of classified characters between the front and back ends.
`default_nettype none
module uitp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire uitp_pkg::class_t push_data,
  input  wire logic             pop,
  output logic                  full,
  output uitp_pkg::q_head_t     head
);

  uitp_pkg::class_t                entries_r [uitp_pkg::Q_DEPTH];
  logic [uitp_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [uitp_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [uitp_pkg::Q_CNT_W-1:0]    count_r, count_nxt;
  logic                            do_pop;

  assign full       = (count_r == uitp_pkg::Q_CNT_W'(uitp_pkg::Q_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.data  = entries_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/uitp_back.sv @@
// Back end: parse state machine, digit accumulator and result register.
`default_nettype none
module uitp_back #(
  parameter int unsigned MAX_LEN     = uitp_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_WIDTH = uitp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [uitp_pkg::BASE_W-1:0]   cfg_base,
  input  wire uitp_pkg::q_head_t             head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output uitp_pkg::out_word_t                out_data
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_LEN);
  localparam int unsigned PW = VALUE_WIDTH + 7;

  typedef enum logic [4:0] {
    PH_DONE   = 5'b00001,
    PH_SPACE  = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_XSEEN  = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [uitp_pkg::BASE_W-1:0]   wbase_r, wbase_nxt;
  logic [VALUE_WIDTH-1:0]        acc_r, acc_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [CW-1:0]                 saved_r, saved_nxt;
  logic                          any_r, any_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          out_valid_r, out_valid_nxt;
  uitp_pkg::out_word_t           out_data_r, out_data_nxt;

  uitp_pkg::class_t              cls;
  logic                          emit;
  logic                          digit_step;
  logic [CW-1:0]                 end_cnt;
  logic [PW-1:0]                 sum;
  logic [CW+uitp_pkg::END_W-1:0] end_wide;
  logic [uitp_pkg::OUT_VAL_W+VALUE_WIDTH-1:0] val_wide;

  assign cls   = head.data;
  assign q_pop = head.valid && (!out_valid_r || out_ready);

  always_comb begin
    phase_nxt  = phase_r;
    wbase_nxt  = wbase_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    saved_nxt  = saved_r;
    any_nxt    = any_r;
    ovf_nxt    = ovf_r;
    emit       = 1'b0;
    digit_step = 1'b0;
    end_cnt    = '0;
    sum        = '0;

    // A start flag opens a new string and drops any string still open.
    if (cls.start) begin
      phase_nxt = PH_SPACE;
      wbase_nxt = cfg_base;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      saved_nxt = '0;
      any_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end

    priority if (phase_nxt == PH_DONE) begin
      emit = 1'b0;
    end else if (cnt_nxt >= LEN_LIMIT) begin
      emit    = 1'b1;
      end_cnt = (phase_nxt == PH_XSEEN) ? saved_nxt : cnt_nxt;
    end else begin
      unique case (phase_nxt)
        PH_SPACE: begin
          if (cls.is_space) begin
            cnt_nxt = cnt_nxt + 1'b1;
          end else if (wbase_nxt == uitp_pkg::BASE_ONE ||
                       wbase_nxt > uitp_pkg::BASE_MAX) begin
            emit    = 1'b1;
            end_cnt = '0;
          end else if (cls.is_zero && (wbase_nxt == uitp_pkg::BASE_AUTO ||
                                       wbase_nxt == uitp_pkg::BASE_HEX)) begin
            phase_nxt = PH_ZERO;
            any_nxt   = 1'b1;
            cnt_nxt   = cnt_nxt + 1'b1;
            saved_nxt = cnt_nxt;
          end else begin
            if (wbase_nxt == uitp_pkg::BASE_AUTO) begin
              wbase_nxt = uitp_pkg::BASE_DEC;
            end
            digit_step = 1'b1;
          end
        end
        PH_ZERO: begin
          if (cls.is_x) begin
            phase_nxt = PH_XSEEN;
            cnt_nxt   = cnt_nxt + 1'b1;
          end else begin
            if (wbase_nxt == uitp_pkg::BASE_AUTO) begin
              wbase_nxt = uitp_pkg::BASE_OCT;
            end
            digit_step = 1'b1;
          end
        end
        PH_XSEEN: begin
          wbase_nxt = uitp_pkg::BASE_HEX;
          // No hex digit after the x: the number ends just after the zero.
          if (cls.digit >= uitp_pkg::BASE_HEX) begin
            emit    = 1'b1;
            end_cnt = saved_nxt;
          end else begin
            digit_step = 1'b1;
          end
        end
        PH_DIGITS: begin
          digit_step = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    if (digit_step) begin
      if (wbase_nxt < uitp_pkg::BASE_TWO || cls.digit >= wbase_nxt) begin
        emit    = 1'b1;
        end_cnt = cnt_nxt;
      end else begin
        sum = {7'b0, acc_nxt} * {{(VALUE_WIDTH + 1){1'b0}}, wbase_nxt}
              + {{(VALUE_WIDTH + 1){1'b0}}, cls.digit};
        ovf_nxt   = ovf_nxt | (|sum[PW-1:VALUE_WIDTH]);
        acc_nxt   = sum[VALUE_WIDTH-1:0];
        any_nxt   = 1'b1;
        cnt_nxt   = cnt_nxt + 1'b1;
        phase_nxt = PH_DIGITS;
      end
    end

    if (emit) begin
      phase_nxt = PH_DONE;
    end
  end

  assign end_wide = {{uitp_pkg::END_W{1'b0}}, end_cnt};
  assign val_wide = {{uitp_pkg::OUT_VAL_W{1'b0}}, acc_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop && emit) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.parsed_value     = val_wide[uitp_pkg::OUT_VAL_W-1:0];
      out_data_nxt.end_offset       = any_nxt ? end_wide[uitp_pkg::END_W-1:0] : '0;
      out_data_nxt.digits_found     = any_nxt;
      out_data_nxt.value_overflowed = ovf_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DONE;
      wbase_r     <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      saved_r     <= '0;
      any_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r <= phase_nxt;
        wbase_r <= wbase_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        saved_r <= saved_nxt;
        any_r   <= any_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ hw/rtl/unsigned_integer_text_parser_core.sv @@
// Top level of the unsigned integer text parser: base register, front, queue and back.
//
//   channel  direction  handshake               word
//   in_      input      in_valid / in_ready     char_code, string_start
//   out_     output     out_valid / out_ready   parsed_value, end_offset, digits_found,
//                                               value_overflowed
//   cfg_     input      cfg_we                  cfg_wdata
//
// One character per cycle is sustained while results are taken; out_valid rises once the
// character that ends its number has passed a queue entry and then the result register.
// The per-character multiply-add by the base in the back end sets that rate.
// Reset is synchronous and clears the queue, the parse state and the result valid;
// the base register returns to 10. A stalled result holds the back end, and the
// two-entry queue lets the input keep taking words until it fills.
`default_nettype none
module unsigned_integer_text_parser_core #(
  parameter int unsigned MAX_LEN     = uitp_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_WIDTH = uitp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire uitp_pkg::in_word_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output uitp_pkg::out_word_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [uitp_pkg::BASE_W-1:0] cfg_wdata
);

  logic [uitp_pkg::BASE_W-1:0] base_r, base_nxt;
  logic                        q_full;
  logic                        q_push;
  uitp_pkg::class_t            q_push_data;
  logic                        q_pop;
  uitp_pkg::q_head_t           q_head;

  assign base_nxt = cfg_we ? cfg_wdata : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= uitp_pkg::BASE_RESET;
    end else begin
      base_r <= base_nxt;
    end
  end

  uitp_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  uitp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .head      (q_head)
  );

  uitp_back #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_base  (base_r),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ hw/rtl/uitp_checker.sv @@
// Port-level checker for the unsigned integer text parser and its bind statement.
`default_nettype none
module uitp_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire uitp_pkg::out_word_t         out_data
);

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid set right after reset");

  // Without a digit there is no value and no end offset.
  a_no_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.digits_found |->
      out_data.end_offset == '0 && out_data.parsed_value == '0)
    else $error("result without digits carries a value or offset");

  a_ovf_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_overflowed |-> out_data.digits_found)
    else $error("overflow flagged without any digit");

  // The input only backs up when a result word was stalled the cycle before.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready) && out_valid)
    else $error("input stalled without a stalled result");

endmodule

bind unsigned_integer_text_parser_core uitp_checker u_uitp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ tb/unsigned_integer_text_parser_core_tb.sv @@
// Self-checking testbench for the unsigned integer text parser core.
module unsigned_integer_text_parser_core_tb;
  import uitp_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 1950;
  localparam int MAX_REPORTS  = 10;
  localparam logic [BASE_W-1:0] BASE_PAST_MAX = 6'd37;
  localparam logic [BASE_W-1:0] BASE_TOP      = 6'd63;

  typedef enum logic [2:0] {P_IDLE, P_BLANKS, P_LEAD0, P_XMARK, P_DIGITS} parse_phase_t;

  typedef struct packed {
    logic              set_base;
    logic [BASE_W-1:0] base;
    in_word_t          word;
    logic              typed;
    out_word_t         want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_data;
  logic              cfg_we;
  logic [BASE_W-1:0] cfg_wdata;

  unsigned_integer_text_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Parser state mirrored by the predictor.
  logic [BASE_W-1:0] radix_reg;
  parse_phase_t      ph;
  logic [BASE_W-1:0] cur_radix;
  logic [63:0]       acc;
  logic [12:0]       nchars;
  logic [12:0]       zero_end;
  logic              got_digit;
  logic              wrapped;

  out_word_t pending_numbers[$];
  dir_row_t  dir_table[$];

  int  mismatches = 0;
  int  n_words = 0;
  int  n_numbers = 0;
  int  n_wrapped = 0;
  int  n_empty = 0;
  int  n_settings = 0;
  int  burst_left = 0;
  int  quiet_cycles = 0;
  bit  hold_go = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [DIGIT_W-1:0] char_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_W'(c - CH_ZERO);
    if (c >= CH_LOA && c <= CH_LOZ) return DIGIT_W'(c - CH_LOA + 8'd10);
    if (c >= CH_UPA && c <= CH_UPZ) return DIGIT_W'(c - CH_UPA + 8'd10);
    return DIGIT_NONE;
  endfunction

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return 8'(int'(CH_ZERO) + v);
    if ($urandom_range(0, 1) == 0) return 8'(int'(CH_LOA) + v - 10);
    return 8'(int'(CH_UPA) + v - 10);
  endfunction

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(0, 2) == 0) return CH_SPACE;
    return 8'($urandom_range(int'(CH_TAB), int'(CH_CR)));
  endfunction

  function automatic out_word_t close_number(input logic [12:0] end_pos);
    out_word_t r;
    r.parsed_value     = acc;
    r.end_offset       = got_digit ? end_pos[END_W-1:0] : '0;
    r.digits_found     = got_digit;
    r.value_overflowed = wrapped;
    ph = P_IDLE;
    return r;
  endfunction

  // Advances the mirrored parser by one word; returns 1 when a number is finished.
  function automatic bit parse_char(input in_word_t w, output out_word_t r);
    logic [DIGIT_W-1:0] d;
    logic [71:0]        wide;
    r = '0;
    if (w.string_start) begin
      ph        = P_BLANKS;
      cur_radix = radix_reg;
      acc       = '0;
      nchars    = '0;
      zero_end  = '0;
      got_digit = 1'b0;
      wrapped   = 1'b0;
    end
    if (ph == P_IDLE) return 1'b0;
    if (nchars >= 13'(MAX_LEN_DEF)) begin
      r = close_number(ph == P_XMARK ? zero_end : nchars);
      return 1'b1;
    end
    d = char_value(w.char_code);
    case (ph)
      P_BLANKS: begin
        if (is_blank(w.char_code)) begin
          nchars++;
          return 1'b0;
        end
        if (cur_radix == BASE_ONE || cur_radix > BASE_MAX) begin
          r = close_number('0);
          return 1'b1;
        end
        if (w.char_code == CH_ZERO && (cur_radix == BASE_AUTO || cur_radix == BASE_HEX)) begin
          ph        = P_LEAD0;
          got_digit = 1'b1;
          nchars++;
          zero_end  = nchars;
          return 1'b0;
        end
        if (cur_radix == BASE_AUTO) cur_radix = BASE_DEC;
        ph = P_DIGITS;
      end
      P_LEAD0: begin
        if (w.char_code == CH_LOX || w.char_code == CH_UPX) begin
          ph = P_XMARK;
          nchars++;
          return 1'b0;
        end
        if (cur_radix == BASE_AUTO) cur_radix = BASE_OCT;
        ph = P_DIGITS;
      end
      P_XMARK: begin
        // A prefix with no hex digit behind it ends the number after the zero.
        cur_radix = BASE_HEX;
        if (d >= BASE_HEX) begin
          r = close_number(zero_end);
          return 1'b1;
        end
        ph = P_DIGITS;
      end
      default: ;
    endcase
    if (cur_radix < BASE_TWO || d >= cur_radix) begin
      r = close_number(nchars);
      return 1'b1;
    end
    wide = {8'd0, acc} * {66'd0, cur_radix} + {66'd0, d};
    if (wide[71:64] != 8'd0) wrapped = 1'b1;
    acc       = wide[63:0];
    got_digit = 1'b1;
    nchars++;
    return 1'b0;
  endfunction

  function automatic int gap_len();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(30, 80);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic dir_row_t tab_row(input logic sb, input logic [BASE_W-1:0] b,
                                       input logic [7:0] c, input logic st, input logic t,
                                       input logic [63:0] v, input logic [END_W-1:0] e,
                                       input logic dg, input logic ov);
    dir_row_t r;
    r.set_base                = sb;
    r.base                    = b;
    r.word.char_code          = c;
    r.word.string_start       = st;
    r.typed                   = t;
    r.want.parsed_value       = v;
    r.want.end_offset         = e;
    r.want.digits_found       = dg;
    r.want.value_overflowed   = ov;
    return r;
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    int        g;
    bit        got;
    out_word_t res;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    n_words++;
    got = parse_char(w, res);
    if (typed) pending_numbers.push_back(want);
    else if (got) pending_numbers.push_back(res);
  endtask

  // The base register may only change once the block has gone quiet.
  task automatic set_radix(input logic [BASE_W-1:0] b);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    radix_reg = b;
    n_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_string(input logic [BASE_W-1:0] b);
    int         kind;
    int         eff;
    int         nd;
    int         i;
    logic [7:0] seq[$];
    in_word_t   w;
    kind = $urandom_range(0, 99);
    if (kind >= 94) begin
      // Stray words without a start flag; they go to a string still open, else they are dropped.
      repeat ($urandom_range(1, 3)) begin
        w.char_code    = 8'($urandom_range(0, 255));
        w.string_start = 1'b0;
        send_word(w, 1'b0, '0);
      end
    end else if (kind >= 80) begin
      nd = $urandom_range(1, 8);
      for (i = 0; i < nd; i++) begin
        w.char_code    = 8'($urandom_range(0, 255));
        w.string_start = (i == 0) || ($urandom_range(0, 7) == 0);
        send_word(w, 1'b0, '0);
      end
    end else begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) seq.push_back(pick_blank());
      eff = (b >= BASE_TWO && b <= BASE_MAX) ? int'(b) : 10;
      if (b == BASE_AUTO) begin
        case ($urandom_range(0, 2))
          0: begin
            seq.push_back(CH_ZERO);
            seq.push_back($urandom_range(0, 1) ? CH_LOX : CH_UPX);
            eff = 16;
          end
          1: begin
            seq.push_back(CH_ZERO);
            eff = 8;
          end
          default: eff = 10;
        endcase
      end else if (b == BASE_HEX && $urandom_range(0, 1) == 0) begin
        seq.push_back(CH_ZERO);
        seq.push_back($urandom_range(0, 1) ? CH_LOX : CH_UPX);
      end
      nd = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 8);
      repeat (nd) seq.push_back(digit_char($urandom_range(0, eff - 1)));
      // Most strings get one more byte, random or a blank, that may end the number; the rest are left open.
      if ($urandom_range(0, 99) < 85 || seq.size() == 0)
        seq.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : CH_SPACE);
      for (i = 0; i < seq.size(); i++) begin
        w.char_code    = seq[i];
        w.string_start = (i == 0);
        send_word(w, 1'b0, '0);
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int r;
    int run_left;
    bit run_ready;
    out_ready = 1'b0;
    run_left  = 0;
    run_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            run_ready = 1'b1;
            run_left  = $urandom_range(1, 8);
          end else if (r < 80) begin
            run_ready = 1'b0;
            run_left  = $urandom_range(1, 3);
          end else if (r < 95) begin
            run_ready = 1'b1;
            run_left  = $urandom_range(30, 100);
          end else begin
            run_ready = 1'b0;
            run_left  = $urandom_range(15, 40);
          end
        end
        run_left--;
        out_ready <= run_ready;
      end
    end
  end

  always @(posedge clk) begin : check_numbers
    out_word_t want_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_numbers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %h end %0d digits %b wrap %b",
                   out_data.parsed_value, out_data.end_offset,
                   out_data.digits_found, out_data.value_overflowed);
      end else begin
        want_w = pending_numbers.pop_front();
        n_numbers++;
        if (out_data.value_overflowed) n_wrapped++;
        if (!out_data.digits_found) n_empty++;
        if (out_data.parsed_value !== want_w.parsed_value ||
            out_data.end_offset !== want_w.end_offset ||
            out_data.digits_found !== want_w.digits_found ||
            out_data.value_overflowed !== want_w.value_overflowed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: value %h/%h end %0d/%0d digits %b/%b wrap %b/%b",
                     $realtime, out_data.parsed_value, want_w.parsed_value,
                     out_data.end_offset, want_w.end_offset,
                     out_data.digits_found, want_w.digits_found,
                     out_data.value_overflowed, want_w.value_overflowed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                phase_no;
    dir_row_t          r;
    logic [BASE_W-1:0] b;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;

    radix_reg = BASE_RESET;
    ph        = P_IDLE;
    cur_radix = '0;
    acc       = '0;
    nchars    = '0;
    zero_end  = '0;
    got_digit = 1'b0;
    wrapped   = 1'b0;

    // Blanks, then a number in the reset base of ten.
    dir_table.push_back(tab_row(1'b0, '0, CH_SPACE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, CH_TAB, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, "7", 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, ",", 1'b0, 1'b1, 64'd7, 12'd3, 1'b1, 1'b0));
    // A word after the number is finished is dropped.
    dir_table.push_back(tab_row(1'b0, '0, "z", 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    // Automatic base with a hex prefix.
    dir_table.push_back(tab_row(1'b1, BASE_AUTO, CH_ZERO, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, CH_LOX, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, "1", 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, "F", 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, ";", 1'b0, 1'b1, 64'd31, 12'd4, 1'b1, 1'b0));
    // Prefix with no hex digit behind it.
    dir_table.push_back(tab_row(1'b0, '0, CH_ZERO, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, CH_UPX, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, "g", 1'b0, 1'b1, 64'd0, 12'd1, 1'b1, 1'b0));
    // Leading zero selects octal, so an 8 ends the number.
    dir_table.push_back(tab_row(1'b0, '0, CH_ZERO, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, "8", 1'b0, 1'b1, 64'd0, 12'd1, 1'b1, 1'b0));
    // A base of one converts nothing.
    dir_table.push_back(tab_row(1'b1, BASE_ONE, CH_SPACE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, "5", 1'b0, 1'b1, 64'd0, 12'd0, 1'b0, 1'b0));
    // Base 36 with the top letter in both cases, ended by byte FF; then base 63 converts nothing.
    dir_table.push_back(tab_row(1'b1, BASE_MAX, "z", 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, CH_UPZ, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, 8'hFF, 1'b0, 1'b1, 64'd1295, 12'd2, 1'b1, 1'b0));
    dir_table.push_back(tab_row(1'b1, BASE_TOP, "1", 1'b1, 1'b1, 64'd0, 12'd0, 1'b0, 1'b0));
    // Base 2: a new start drops the unfinished string.
    dir_table.push_back(tab_row(1'b1, BASE_TWO, "1", 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, "1", 1'b1, 1'b0, '0, '0, 1'b0, 1'b0));
    dir_table.push_back(tab_row(1'b0, '0, 8'h00, 1'b0, 1'b1, 64'd1, 12'd1, 1'b1, 1'b0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[k]) begin
      r = dir_table[k];
      if (r.set_base) set_radix(r.base);
      send_word(r.word, r.typed, r.want);
    end

    phase_no = 0;
    while (n_words < ITEM_TARGET) begin
      case (phase_no)
        0: b = BASE_AUTO;
        1: b = BASE_HEX;
        2: b = BASE_DEC;
        3: b = BASE_TWO;
        4: b = BASE_OCT;
        5: b = BASE_MAX;
        6: b = BASE_ONE;
        7: b = BASE_PAST_MAX;
        8: b = BASE_TOP;
        default: b = ($urandom_range(0, 9) == 0) ? BASE_W'($urandom_range(37, 63))
                                                 : BASE_W'($urandom_range(0, 36));
      endcase
      set_radix(b);
      if (phase_no == 5) hold_go = 1'b1;
      repeat ($urandom_range(8, 20)) send_string(b);
      phase_no++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d words in, %0d numbers checked over %0d base settings",
             n_words, n_numbers, n_settings);
    $display("Summary: %0d numbers wrapped, %0d had no digits, %0d mismatches",
             n_wrapped, n_empty, mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ unsigned_integer_text_parser_core.f @@
hw/rtl/uitp_pkg.sv
hw/rtl/uitp_front.sv
hw/rtl/uitp_queue.sv
hw/rtl/uitp_back.sv
hw/rtl/unsigned_integer_text_parser_core.sv
hw/rtl/uitp_checker.sv
tb/unsigned_integer_text_parser_core_tb.sv
